@@ rtl/accel_idle_detector_defines.svh @@
// Assertion macros shared by the idle detector RTL.
`ifndef ACCEL_IDLE_DETECTOR_DEFINES_SVH
`define ACCEL_IDLE_DETECTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define AID_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define AID_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define AID_ASSERT(lbl, clk, rst_n, prop)
`define AID_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/aid_pkg.sv @@
// Types and constants shared by the accelerometer idle detector.
package aid_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int THRESH_W   = 16;
	localparam int NEED_W     = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_NEEDED    = 2'd1;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd32;
	localparam logic [NEED_W-1:0]   NEED_RESET   = 24'd100;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic is_idle;
		logic toggled;
	} result_t;

endpackage

@@ rtl/aid_delta.sv @@
// Absolute change of one axis against the stored sample, compared with the threshold.
module aid_delta (
	input  logic signed [aid_pkg::SAMPLE_W-1:0] cur,
	input  logic signed [aid_pkg::SAMPLE_W-1:0] prev,
	input  logic        [aid_pkg::THRESH_W-1:0] threshold,
	output logic                                 calm
);

	logic signed [aid_pkg::SAMPLE_W:0] diff;
	logic        [aid_pkg::SAMPLE_W:0] mag;

	always_comb begin
		diff = {cur[aid_pkg::SAMPLE_W-1], cur} - {prev[aid_pkg::SAMPLE_W-1], prev};
		mag  = diff[aid_pkg::SAMPLE_W] ? ((aid_pkg::SAMPLE_W+1)'(0) - diff) : diff;
		// The magnitude never exceeds 65535, so the top bit is always clear here.
		calm = (mag[aid_pkg::SAMPLE_W-1:0] <= threshold);
	end

endmodule

@@ rtl/aid_state.sv @@
// Previous sample, quiet counter and active/idle state, updated once per transaction.
`include "accel_idle_detector_defines.svh"

module aid_state #(
	parameter int COUNT_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  aid_pkg::sample_t              sample_s1,
	input  logic                          quiet,
	input  logic [aid_pkg::NEED_W-1:0]    needed,
	output aid_pkg::sample_t              prev,
	output aid_pkg::result_t              result_d
);

	localparam int CMP_W = (COUNT_BITS > aid_pkg::NEED_W) ? COUNT_BITS : aid_pkg::NEED_W;

	aid_pkg::sample_t        prev_q;
	logic                    have_prev_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [COUNT_BITS-1:0]   count_d;
	logic                    idle_q;
	logic                    idle_d;
	logic                    changed;
	logic [CMP_W-1:0]        need_ext;

	assign prev     = prev_q;
	assign need_ext = CMP_W'(needed);

	always_comb begin
		count_d = count_q;
		idle_d  = idle_q;
		changed = 1'b0;
		if (have_prev_q) begin
			if (!quiet) begin
				count_d = '0;
				if (idle_q) begin
					idle_d  = 1'b0;
					changed = 1'b1;
				end
			end else begin
				// The counter stops at the target and at its own largest value.
				if ((CMP_W'(count_q) < need_ext) && !(&count_q)) begin
					count_d = count_q + 1'b1;
				end
				if (!idle_q && (CMP_W'(count_d) == need_ext)) begin
					idle_d  = 1'b1;
					changed = 1'b1;
				end
			end
		end
		result_d.is_idle = idle_d;
		result_d.toggled = changed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			count_q     <= '0;
			idle_q      <= 1'b0;
		end else if (adv) begin
			have_prev_q <= 1'b1;
			count_q     <= count_d;
			idle_q      <= idle_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prev_q <= sample_s1;
		end
	end

	`AID_ASSERT(a_hold_without_transaction, clk, arst_n, !adv |=> $stable(count_q) && $stable(idle_q))
	`AID_ASSERT(a_motion_clears, clk, arst_n, adv && have_prev_q && !quiet |=> count_q == '0 && !idle_q)
	`AID_ASSERT(a_first_sample_keeps, clk, arst_n, adv && !have_prev_q |=> count_q == $past(count_q) && idle_q == $past(idle_q))

endmodule

@@ rtl/accel_idle_detector.sv @@
// Top level of the accelerometer idle detector: channels, configuration registers, pipeline.
// One sample is accepted per clock unless the input is stalled; its result is presented on
// the result port through an input register and a result register. The quiet counter
// and active/idle state are updated as the sample moves from one to the other, which
// gives a sustained rate of one transaction per clock while the result is not stalled.
// The input stalls only while both registers are full and the result is stalled. The
// first sample after reset is only stored. Configuration writes are taken at once
// (cfg_ready is always high) and apply from the next sample.
`include "accel_idle_detector_defines.svh"

module accel_idle_detector #(
	parameter int COUNT_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  aid_pkg::sample_t                   sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output aid_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aid_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                            valid_s1;
	aid_pkg::sample_t                sample_s1;
	logic                            valid_s2;
	aid_pkg::result_t                result_s2;
	aid_pkg::result_t                result_d;
	aid_pkg::sample_t                prev;
	logic [aid_pkg::THRESH_W-1:0]    thresh_q;
	logic [aid_pkg::NEED_W-1:0]      needed_q;
	logic                            out_free;
	logic                            adv;
	logic                            accept;
	logic                            quiet;
	logic                            calm_x;
	logic                            calm_y;
	logic                            calm_z;

	assign out_free     = !valid_s2 || !result_stall;
	assign adv          = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;
	assign accept       = sample_valid && !sample_stall;
	assign result_valid = valid_s2;
	assign result       = result_s2;
	assign cfg_ready    = 1'b1;
	assign quiet        = calm_x && calm_y && calm_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= aid_pkg::THRESH_RESET;
			needed_q <= aid_pkg::NEED_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				aid_pkg::CFG_DELTA_THRESHOLD: thresh_q <= cfg_data[aid_pkg::THRESH_W-1:0];
				aid_pkg::CFG_QUIET_NEEDED:    needed_q <= cfg_data[aid_pkg::NEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
		if (adv) begin
			result_s2 <= result_d;
		end
	end

	aid_delta u_delta_x (
		.cur       (sample_s1.accel_x),
		.prev      (prev.accel_x),
		.threshold (thresh_q),
		.calm      (calm_x)
	);

	aid_delta u_delta_y (
		.cur       (sample_s1.accel_y),
		.prev      (prev.accel_y),
		.threshold (thresh_q),
		.calm      (calm_y)
	);

	aid_delta u_delta_z (
		.cur       (sample_s1.accel_z),
		.prev      (prev.accel_z),
		.threshold (thresh_q),
		.calm      (calm_z)
	);

	aid_state #(
		.COUNT_BITS (COUNT_BITS)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.sample_s1 (sample_s1),
		.quiet     (quiet),
		.needed    (needed_q),
		.prev      (prev),
		.result_d  (result_d)
	);

	`AID_ASSERT(a_stall_only_when_full, clk, arst_n, sample_stall |-> valid_s1 && valid_s2)
	`AID_ASSERT(a_result_follows_stage, clk, arst_n, adv |=> valid_s2)
	`AID_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !valid_s1 && !valid_s2)

endmodule

@@ test/accel_idle_detector_test.sv @@
// Self-checking testbench for the accelerometer idle detector.
`timescale 1ns / 1ps

module accel_idle_detector_test;

	localparam int COUNT_BITS = 24;
	localparam int unsigned COUNT_TOP = (1 << COUNT_BITS) - 1;
	localparam int SAMPLE_TARGET = 1725;
	localparam logic [aid_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [aid_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef enum {STEP_WITHIN, STEP_AT_LIMIT, STEP_PAST_LIMIT} step_kind_t;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           sample_valid = 1'b0;
	logic                           sample_stall;
	aid_pkg::sample_t               sample       = '0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	aid_pkg::result_t               result;
	logic                           cfg_valid    = 1'b0;
	logic                           cfg_ready;
	logic [aid_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [aid_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// Predictor state and its copy of the registers.
	logic [aid_pkg::THRESH_W-1:0] thresh_now  = aid_pkg::THRESH_RESET;
	logic [aid_pkg::NEED_W-1:0]   need_now    = aid_pkg::NEED_RESET;
	aid_pkg::sample_t             last_sample = '0;
	bit                           have_last   = 1'b0;
	int unsigned                  quiet_run   = 0;
	bit                           idle_now    = 1'b0;

	aid_pkg::sample_t pending_samples[$];
	aid_pkg::result_t predicted_status[$];

	bit sample_taken = 1'b0;
	bit idling_on    = 1'b1;
	int send_wait    = 0;
	int stall_left   = 0;
	int errors       = 0;
	int samples_queued = 0;

	// Generator side: last queued sample and the threshold it aims at.
	int gen_x = 0;
	int gen_y = 0;
	int gen_z = 0;
	int gen_limit = 32;

	accel_idle_detector #(
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic aid_pkg::result_t predict_status(input aid_pkg::sample_t s);
		aid_pkg::result_t r;
		int dx;
		int dy;
		int dz;
		bit quiet;
		bit flipped;
		flipped = 1'b0;
		if (!have_last) begin
			have_last = 1'b1;
		end else begin
			dx = int'(s.accel_x) - int'(last_sample.accel_x);
			dy = int'(s.accel_y) - int'(last_sample.accel_y);
			dz = int'(s.accel_z) - int'(last_sample.accel_z);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dz < 0) dz = -dz;
			quiet = dx <= int'(thresh_now) && dy <= int'(thresh_now) &&
				dz <= int'(thresh_now);
			if (!quiet) begin
				quiet_run = 0;
				if (idle_now) begin
					idle_now = 1'b0;
					flipped = 1'b1;
				end
			end else begin
				// The count holds once it reaches the target or its own ceiling.
				if (quiet_run < need_now && quiet_run < COUNT_TOP)
					quiet_run++;
				if (!idle_now && quiet_run == need_now) begin
					idle_now = 1'b1;
					flipped = 1'b1;
				end
			end
		end
		last_sample = s;
		r.is_idle = idle_now;
		r.toggled = flipped;
		return r;
	endfunction

	// Sample driver: a new transaction is offered once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || sample_taken)) begin
			if (send_wait > 0) begin
				send_wait--;
				sample_valid <= 1'b0;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				send_wait = $urandom_range(0, 6);
				sample_valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				sample <= pending_samples.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Result receiver stalls in bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 6);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		aid_pkg::result_t want;
		sample_taken <= arst_n && sample_valid && !sample_stall;
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				aid_pkg::CFG_DELTA_THRESHOLD: thresh_now = cfg_data[aid_pkg::THRESH_W-1:0];
				aid_pkg::CFG_QUIET_NEEDED: need_now = cfg_data[aid_pkg::NEED_W-1:0];
				default: ;
			endcase
		end
		if (arst_n && sample_valid && !sample_stall)
			predicted_status.push_back(predict_status(sample));
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_status.size() == 0) begin
				$display("%0t: unexpected result transaction: idle=%b toggled=%b",
					$time, result.is_idle, result.toggled);
				errors++;
			end else begin
				want = predicted_status.pop_front();
				if (result.is_idle !== want.is_idle) begin
					$display("%0t: is_idle mismatch: expected %b, actual %b",
						$time, want.is_idle, result.is_idle);
					errors++;
				end
				if (result.toggled !== want.toggled) begin
					$display("%0t: toggled mismatch: expected %b, actual %b",
						$time, want.toggled, result.toggled);
					errors++;
				end
			end
		end
	end

	task automatic push_sample(input int x, input int y, input int z);
		aid_pkg::sample_t s;
		s.accel_x = aid_pkg::SAMPLE_W'(x);
		s.accel_y = aid_pkg::SAMPLE_W'(y);
		s.accel_z = aid_pkg::SAMPLE_W'(z);
		pending_samples.push_back(s);
		gen_x = x;
		gen_y = y;
		gen_z = z;
		samples_queued++;
	endtask

	function automatic int nudge_axis(input int base, input int limit, input step_kind_t kind);
		int mag;
		int v;
		case (kind)
			STEP_WITHIN: mag = $urandom_range(0, limit);
			STEP_AT_LIMIT: mag = limit;
			default: mag = limit + 1;
		endcase
		if ($urandom_range(0, 1) == 1) mag = -mag;
		if (base + mag > 32767 || base + mag < -32768) mag = -mag;
		v = base + mag;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	function automatic step_kind_t axis_kind(input int axis, input int pick, input step_kind_t k);
		return (axis == pick) ? k : STEP_WITHIN;
	endfunction

	task automatic push_step(input step_kind_t k, input int pick);
		push_sample(nudge_axis(gen_x, gen_limit, axis_kind(0, pick, k)),
			nudge_axis(gen_y, gen_limit, axis_kind(1, pick, k)),
			nudge_axis(gen_z, gen_limit, axis_kind(2, pick, k)));
	endtask

	// Waits until every queued sample has been sent and its result checked.
	task automatic drain_results();
		while (pending_samples.size() != 0 || sample_valid || predicted_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [aid_pkg::CFG_IDX_W-1:0] idx,
			input logic [aid_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#1000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int phase;
		int thr;
		int phase_end;
		int run_cap;
		logic [aid_pkg::NEED_W-1:0] need;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The first sample is only stored, then a full-scale swing on the x and y axes.
		push_sample(32767, -32768, 0);
		push_sample(-32768, 32767, -1);
		drain_results();
		write_reg(aid_pkg::CFG_QUIET_NEEDED, 24'd1);
		push_sample(-32768, 32767, -1);
		push_sample(-32768, 32767, -1);
		push_sample(-32736, 32767, -1);
		push_sample(-32736, 32734, -1);
		push_sample(-32736, 32734, -33);
		drain_results();
		// Upper data bits are dropped: threshold zero, with a zero target.
		write_reg(aid_pkg::CFG_DELTA_THRESHOLD, 24'hFF0000);
		write_reg(aid_pkg::CFG_QUIET_NEEDED, 24'd0);
		write_reg(CFG_SPARE_2, 24'hFFFFFF);
		push_sample(-32736, 32734, -32);
		push_sample(-32736, 32734, -32);
		push_sample(-32736, 32734, -32);
		drain_results();
		write_reg(aid_pkg::CFG_DELTA_THRESHOLD, 24'h00FFFF);
		write_reg(aid_pkg::CFG_QUIET_NEEDED, 24'd3);
		write_reg(CFG_SPARE_3, 24'h5A5A5A);
		push_sample(32767, 32767, 32767);
		push_sample(-32768, -32768, -32768);
		drain_results();
		write_reg(aid_pkg::CFG_DELTA_THRESHOLD, 24'd16);
		write_reg(aid_pkg::CFG_QUIET_NEEDED, 24'd10);
		push_sample(0, 0, 0);
		push_sample(16, -16, 0);
		push_sample(10, -5, 16);
		push_sample(0, 0, 0);
		push_sample(-16, 16, 5);
		push_sample(-20, 10, 0);
		drain_results();
		// The target now sits below the count, so quiet samples cannot reach it.
		write_reg(aid_pkg::CFG_QUIET_NEEDED, 24'd2);
		push_sample(-20, 10, 0);
		push_sample(-10, 10, 0);
		push_sample(1000, 10, 0);
		push_sample(1000, 10, 0);
		push_sample(1010, 20, -10);

		for (phase = 0; samples_queued < SAMPLE_TARGET; phase++) begin
			case (phase % 6)
				0: begin thr = 0; need = 24'd1; end
				1: begin thr = 65535; need = 24'd0; end
				2: begin
					thr = $urandom_range(1, 64);
					need = aid_pkg::NEED_W'($urandom_range(1, 20));
				end
				3: begin
					thr = $urandom_range(0, 65535);
					need = ($urandom_range(0, 1) == 1) ? 24'hFFFFFF :
						aid_pkg::NEED_W'($urandom);
				end
				4: begin
					thr = $urandom_range(0, 300);
					need = aid_pkg::NEED_W'($urandom_range(1, 40));
				end
				default: begin
					thr = $urandom_range(0, 32);
					need = aid_pkg::NEED_W'($urandom_range(1, 8));
				end
			endcase
			drain_results();
			write_reg(aid_pkg::CFG_DELTA_THRESHOLD, {8'($urandom), aid_pkg::THRESH_W'(thr)});
			write_reg(aid_pkg::CFG_QUIET_NEEDED, need);
			if ($urandom_range(0, 2) == 0)
				write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_2 : CFG_SPARE_3,
					aid_pkg::CFG_DATA_W'($urandom));
			gen_limit = thr;
			idling_on = (samples_queued < SAMPLE_TARGET - 300) && ($urandom_range(0, 4) != 0);
			run_cap = (need <= 40) ? int'(need) + 3 : 30;
			phase_end = samples_queued + 150;
			while (samples_queued < phase_end) begin
				repeat ($urandom_range(1, run_cap)) begin
					if ($urandom_range(0, 3) == 0)
						push_step(STEP_AT_LIMIT, $urandom_range(0, 2));
					else
						push_step(STEP_WITHIN, 3);
				end
				if ($urandom_range(0, 1) == 1)
					push_step(STEP_PAST_LIMIT, $urandom_range(0, 2));
				else
					push_sample($urandom_range(0, 65535) - 32768,
						$urandom_range(0, 65535) - 32768,
						$urandom_range(0, 65535) - 32768);
			end
		end

		idling_on = 1'b0;
		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0 && predicted_status.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/aid_pkg.sv
rtl/aid_delta.sv
rtl/aid_state.sv
rtl/accel_idle_detector.sv
test/accel_idle_detector_test.sv
